[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Action codes and fixed field widths of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ACTION_BITS  = 3;
    localparam int PRIO_BITS    = 16;
    localparam int OUT_PL_BITS  = 32;
    localparam int COUNT_BITS   = 7;

    localparam logic [ACTION_BITS-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE     = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_PEEK_FRONT = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_PEEK_TAIL  = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR      = 3'd4;

endpackage

[hdl/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue, highest priority first, stable for equal keys.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one action per transfer (insert, remove front, peek front,
//   peek tail, clear) with priority and payload for inserts. m_ channel returns
//   one result per action: ok, entry priority/payload, count, empty flag.
//   Entries live in one RAM used as a circular buffer (head pointer + count).
//   Clear, failed actions and insert into an empty queue go straight to the
//   result register; remove/peek first pass through the RAM read state.
//   Insert walks from the tail toward the head, moving one entry per cycle,
//   until it reaches an entry not ranked below the new one, or the head.
//   One action is in flight at a time; s_ready is high only when idle.
//   Reset empties the queue; RAM contents are not cleared.
//   A stalled m_ready holds the result in the output register and the block
//   keeps the next result pending until that transfer completes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [spq_pkg::ACTION_BITS-1:0]       s_action,
    input  logic [spq_pkg::PRIO_BITS-1:0]         s_priority_req,
    input  logic [spq_pkg::OUT_PL_BITS-1:0]       s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_ok,
    output logic [spq_pkg::PRIO_BITS-1:0]         m_out_priority,
    output logic [spq_pkg::OUT_PL_BITS-1:0]       m_out_payload,
    output logic [spq_pkg::COUNT_BITS-1:0]        m_count,
    output logic                                  m_empty_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SB = (PAYLOAD_BITS < spq_pkg::OUT_PL_BITS) ?
                        PAYLOAD_BITS : spq_pkg::OUT_PL_BITS;
    localparam int PB = spq_pkg::PRIO_BITS;
    localparam int EW = PB + SB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INS,
        ST_INS_HEAD,
        ST_DONE
    } state_t;

    state_t           st_reg;
    logic [CW-1:0]    cnt_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    k_reg;
    logic [PB-1:0]    new_prio_reg;
    logic [SB-1:0]    new_data_reg;
    logic             res_ok_reg;
    logic [PB-1:0]    res_prio_reg;
    logic [SB-1:0]    res_data_reg;

    logic             m_valid_reg;
    logic             m_ok_reg;
    logic [PB-1:0]    m_prio_reg;
    logic [spq_pkg::OUT_PL_BITS-1:0] m_data_reg;
    logic [spq_pkg::COUNT_BITS-1:0]  m_count_reg;
    logic             m_empty_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;

    logic             accept;
    logic             is_empty;
    logic             is_full;
    logic [AW:0]      tail_sum;
    logic [AW-1:0]    tail_ptr;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    rd_inc;
    logic [AW-1:0]    rd_dec;
    logic [PB-1:0]    rd_prio;
    logic             shift_down;
    logic             out_free;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    assign s_ready  = (st_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == CW'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    // tail = head + count - 1, wrapped once
    assign tail_sum = {1'b0, head_reg} + (AW+1)'(cnt_reg) - (AW+1)'(1);
    assign tail_ptr = (tail_sum >= (AW+1)'(DEPTH)) ?
                      AW'(tail_sum - (AW+1)'(DEPTH)) : AW'(tail_sum);
    assign head_inc = ptr_inc(head_reg);
    assign rd_inc   = ptr_inc(rd_ptr_reg);
    assign rd_dec   = ptr_dec(rd_ptr_reg);
    assign rd_prio  = ram_rdata[EW-1:SB];
    // stored entry ranks below the new one: move it one slot back
    assign shift_down = (rd_prio < new_prio_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = {new_prio_reg, new_data_reg};
        ram_raddr = head_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept && s_action == spq_pkg::ACT_INSERT && is_empty) begin
                    ram_we    = 1'b1;
                    ram_wdata = {s_priority_req, s_payload[SB-1:0]};
                end
                if (s_action == spq_pkg::ACT_PEEK_TAIL ||
                    s_action == spq_pkg::ACT_INSERT) begin
                    ram_raddr = tail_ptr;
                end
            end
            ST_INS: begin
                ram_we    = 1'b1;
                ram_waddr = rd_inc;
                ram_raddr = rd_dec;
                if (shift_down) begin
                    ram_wdata = ram_rdata;
                end
            end
            ST_INS_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = rd_ptr_reg;
            end
            default: begin
            end
        endcase
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            cnt_reg     <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        new_prio_reg <= s_priority_req;
                        new_data_reg <= s_payload[SB-1:0];
                        res_ok_reg   <= 1'b0;
                        res_prio_reg <= '0;
                        res_data_reg <= '0;
                        st_reg       <= ST_DONE;
                        unique case (s_action)
                            spq_pkg::ACT_INSERT: begin
                                if (!is_full) begin
                                    res_ok_reg <= 1'b1;
                                    cnt_reg    <= cnt_reg + CW'(1);
                                    if (!is_empty) begin
                                        rd_ptr_reg <= tail_ptr;
                                        k_reg      <= AW'(cnt_reg - CW'(1));
                                        st_reg     <= ST_INS;
                                    end
                                end
                            end
                            spq_pkg::ACT_REMOVE: begin
                                if (!is_empty) begin
                                    res_ok_reg <= 1'b1;
                                    head_reg   <= head_inc;
                                    cnt_reg    <= cnt_reg - CW'(1);
                                    st_reg     <= ST_READ;
                                end
                            end
                            spq_pkg::ACT_PEEK_FRONT,
                            spq_pkg::ACT_PEEK_TAIL: begin
                                if (!is_empty) begin
                                    res_ok_reg <= 1'b1;
                                    st_reg     <= ST_READ;
                                end
                            end
                            spq_pkg::ACT_CLEAR: begin
                                res_ok_reg <= 1'b1;
                                cnt_reg    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    res_prio_reg <= rd_prio;
                    res_data_reg <= ram_rdata[SB-1:0];
                    st_reg       <= ST_DONE;
                end
                ST_INS: begin
                    if (!shift_down) begin
                        st_reg <= ST_DONE;
                    end else if (k_reg == '0) begin
                        st_reg <= ST_INS_HEAD;
                    end else begin
                        rd_ptr_reg <= rd_dec;
                        k_reg      <= k_reg - AW'(1);
                    end
                end
                ST_INS_HEAD: begin
                    st_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_ok_reg    <= res_ok_reg;
                        m_prio_reg  <= res_prio_reg;
                        m_data_reg  <= spq_pkg::OUT_PL_BITS'(res_data_reg);
                        m_count_reg <= spq_pkg::COUNT_BITS'(cnt_reg);
                        m_empty_reg <= is_empty;
                        st_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_out_priority = m_prio_reg;
    assign m_out_payload  = m_data_reg;
    assign m_count        = m_count_reg;
    assign m_empty_res    = m_empty_reg;

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= CW'(DEPTH), "entry count above depth")
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, accept |=> !s_ready, "second action taken while busy")
    `ASSERT_CLK(a_ins_walk, aclk, aresetn, (st_reg == ST_INS) |-> !is_empty, "insert walk on empty queue")

endmodule

[bench/tb_stable_priority_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue. A behavioral sorted list
// predicts every result; directed corner tests, one with a long output stall,
// are followed by random traffic with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

    localparam int DEPTH     = 64;
    localparam int MAX_CYCLES = 2000000;

    typedef struct packed {
        logic        ok;
        logic [15:0] prio;
        logic [31:0] data;
        logic [6:0]  count;
        logic        empty;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [15:0] s_priority_req = '0;
    logic [31:0] s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [15:0] m_out_priority;
    logic [31:0] m_out_payload;
    logic [6:0]  m_count;
    logic        m_empty_res;

    // shadow queue: slot 0 is the head
    logic [15:0] q_prio[$];
    logic [31:0] q_data[$];
    result_t     pending_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          rx_wait = 0;
    bit          hold_off = 1'b0;

    always #10 aclk = ~aclk;

    stable_priority_queue #(.DEPTH(DEPTH), .PAYLOAD_BITS(32)) dut (.*);

    function automatic result_t predict_queue(logic [2:0] act, logic [15:0] pr,
                                              logic [31:0] pl);
        result_t r;
        int pos;
        r = '0;
        case (act)
            spq_pkg::ACT_INSERT: begin
                if (q_prio.size() < DEPTH) begin
                    pos = 0;
                    while (pos < q_prio.size() && q_prio[pos] >= pr) pos++;
                    q_prio.insert(pos, pr);
                    q_data.insert(pos, pl);
                    r.ok = 1'b1;
                end
            end
            spq_pkg::ACT_REMOVE: begin
                if (q_prio.size() > 0) begin
                    r.ok = 1'b1;
                    r.prio = q_prio.pop_front();
                    r.data = q_data.pop_front();
                end
            end
            spq_pkg::ACT_PEEK_FRONT: begin
                if (q_prio.size() > 0) begin
                    r.ok = 1'b1;
                    r.prio = q_prio[0];
                    r.data = q_data[0];
                end
            end
            spq_pkg::ACT_PEEK_TAIL: begin
                if (q_prio.size() > 0) begin
                    r.ok = 1'b1;
                    r.prio = q_prio[$];
                    r.data = q_data[$];
                end
            end
            spq_pkg::ACT_CLEAR: begin
                q_prio.delete();
                q_data.delete();
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = 7'(q_prio.size());
        r.empty = (q_prio.size() == 0);
        return r;
    endfunction

    task automatic send_action(logic [2:0] act, logic [15:0] pr, logic [31:0] pl);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        // with no gap, s_valid stays high into the next transfer
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_priority_req <= pr;
        s_payload      <= pl;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_queue(act, pr, pl));
    endtask

    // receiver: draws a stall before each transfer, or is held off entirely
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_wait = $urandom_range(0, 16);
            m_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            got = {m_ok, m_out_priority, m_out_payload, m_count, m_empty_res};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok) begin
                    $display("%0t: ok exp %h got %h", $time, want.ok, got.ok);
                    errors++;
                end
                if (got.prio !== want.prio) begin
                    $display("%0t: prio exp %h got %h", $time, want.prio, got.prio);
                    errors++;
                end
                if (got.data !== want.data) begin
                    $display("%0t: payload exp %h got %h", $time, want.data, got.data);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                    errors++;
                end
                if (got.empty !== want.empty) begin
                    $display("%0t: empty exp %h got %h", $time, want.empty, got.empty);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_reads;
        send_action(spq_pkg::ACT_REMOVE, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_PEEK_FRONT, 16'hFFFF, 32'hFFFF_FFFF);
        send_action(spq_pkg::ACT_PEEK_TAIL, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_CLEAR, 16'h0, 32'h0);
        send_action(3'd5, 16'h1234, 32'h0);
        send_action(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_ordering;
        // equal keys must come out in arrival order
        send_action(spq_pkg::ACT_INSERT, 16'h0000, 32'h0000_0000);
        send_action(spq_pkg::ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_action(spq_pkg::ACT_INSERT, 16'h8000, 32'hA5A5_A5A5);
        send_action(spq_pkg::ACT_INSERT, 16'h8000, 32'h5A5A_5A5A);
        send_action(spq_pkg::ACT_INSERT, 16'h0000, 32'h1111_1111);
        send_action(3'd6, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_PEEK_FRONT, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_PEEK_TAIL, 16'h0, 32'h0);
        repeat (5) send_action(spq_pkg::ACT_REMOVE, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_REMOVE, 16'h0, 32'h0);
    endtask

    task automatic test_full_queue;
        // long output stall while the sender keeps offering: fills and stalls
        hold_off <= 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off <= 1'b0;
            end
            repeat (DEPTH + 1)
                send_action(spq_pkg::ACT_INSERT, 16'($urandom_range(0, 3)), $urandom);
        join
        send_action(spq_pkg::ACT_PEEK_TAIL, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_CLEAR, 16'h0, 32'h0);
        send_action(spq_pkg::ACT_PEEK_FRONT, 16'h0, 32'h0);
    endtask

    task automatic test_random_traffic;
        int sel;
        logic [2:0] act;
        logic [15:0] pr;
        for (int i = 0; i < 700; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)      act = spq_pkg::ACT_INSERT;
            else if (sel < 75) act = spq_pkg::ACT_REMOVE;
            else if (sel < 85) act = spq_pkg::ACT_PEEK_FRONT;
            else if (sel < 95) act = spq_pkg::ACT_PEEK_TAIL;
            else if (sel < 98) act = spq_pkg::ACT_CLEAR;
            else               act = 3'($urandom_range(5, 7));
            // narrow keys give plenty of ties
            pr = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            send_action(act, pr, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_reads();
        test_ordering();
        test_full_queue();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 20) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
